### rtl/ir_pulse_distance_transmitter_macros.svh
// Assertion macros shared by the IR pulse-distance transmitter RTL.
`ifndef IR_PULSE_DISTANCE_TRANSMITTER_MACROS_SVH
`define IR_PULSE_DISTANCE_TRANSMITTER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define IPDT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define IPDT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/ipdt_pkg.sv
// Shared types and constants of the IR pulse-distance transmitter.
package ipdt_pkg;

   localparam int FRAME_BITS = 72;
   localparam int BIT_IDX_W  = $clog2(FRAME_BITS + 1);
   localparam int HIGH_BITS  = FRAME_BITS - 64;

   localparam int HALF_W     = 8;
   localparam int CYC_W      = 10;
   localparam int SPACE_W    = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;

   localparam logic [HALF_W-1:0]  CARRIER_HALF_RST = 8'd13;
   localparam logic [CYC_W-1:0]   LEAD_BURST_RST   = 10'd322;
   localparam logic [SPACE_W-1:0] LEAD_SPACE_RST   = 16'd4500;
   localparam logic [CYC_W-1:0]   BIT_BURST_RST    = 10'd19;
   localparam logic [SPACE_W-1:0] ONE_SPACE_RST    = 16'd1750;
   localparam logic [SPACE_W-1:0] ZERO_SPACE_RST   = 16'd638;
   localparam logic [CYC_W-1:0]   END_BURST_RST    = 10'd19;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CARRIER_HALF = 3'd0,
      REG_LEAD_BURST   = 3'd1,
      REG_LEAD_SPACE   = 3'd2,
      REG_BIT_BURST    = 3'd3,
      REG_ONE_SPACE    = 3'd4,
      REG_ZERO_SPACE   = 3'd5,
      REG_END_BURST    = 3'd6
   } csr_index_type;

   typedef enum logic {
      KIND_TICK  = 1'b0,
      KIND_START = 1'b1
   } kind_type;

   typedef enum logic [5:0] {
      PH_IDLE   = 6'b000001,
      PH_LEAD_B = 6'b000010,
      PH_LEAD_S = 6'b000100,
      PH_BIT_B  = 6'b001000,
      PH_BIT_S  = 6'b010000,
      PH_END_B  = 6'b100000
   } phase_type;

endpackage

### rtl/ipdt_if.sv
// Request and response channel interfaces of the IR pulse-distance transmitter.
interface ipdt_req_if import ipdt_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [63:0]          frame_low;
   logic [HIGH_BITS-1:0] frame_high;

   modport source (output valid, kind, frame_low, frame_high, input ready);
   modport sink   (input valid, kind, frame_low, frame_high, output ready);
endinterface

interface ipdt_rsp_if import ipdt_pkg::*; ();
   logic valid;
   logic ready;
   logic ir_level;
   logic busy_res;
   logic frame_done;

   modport source (output valid, ir_level, busy_res, frame_done, input ready);
   modport sink   (input valid, ir_level, busy_res, frame_done, output ready);
endinterface

### rtl/ir_pulse_distance_transmitter.sv
// IR pulse-distance transmitter: a start beat loads a 72-bit frame and each tick beat
// returns the modulated emitter level for one microsecond. The block takes one beat per
// clock cycle: a beat goes into an input register, then all segment sequencing and the
// carrier counters are evaluated in one pass and the result lands in the output
// register; the throughput is one beat per cycle as long as the response side keeps
// taking beats. The request ready follows the response ready through the two register
// stages. Segments of zero length are skipped within the same pass, including runs of
// data bits whose burst and space are both empty, using a lowest-set-bit search over the
// frame. The user must write configuration registers through the csr port only while no
// frame is in flight; the block does not enforce it; a write to an unused index is dropped.
`include "ir_pulse_distance_transmitter_macros.svh"

module ir_pulse_distance_transmitter import ipdt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ipdt_req_if.sink              req_if,
   ipdt_rsp_if.source            rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers.
   logic [HALF_W-1:0]  carrier_half_ff;
   logic [CYC_W-1:0]   lead_burst_ff;
   logic [SPACE_W-1:0] lead_space_ff;
   logic [CYC_W-1:0]   bit_burst_ff;
   logic [SPACE_W-1:0] one_space_ff;
   logic [SPACE_W-1:0] zero_space_ff;
   logic [CYC_W-1:0]   end_burst_ff;

   // Input register stage.
   logic                 s1_vld_ff, s1_vld_in;
   logic                 s1_kind_ff;
   logic [63:0]          s1_frame_low_ff;
   logic [HIGH_BITS-1:0] s1_frame_high_ff;

   // Output register stage.
   logic rsp_vld_ff, rsp_vld_in;
   logic rsp_level_ff, rsp_busy_ff, rsp_done_ff;

   // Transmitter state.
   phase_type             phase_ff, phase_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic [BIT_IDX_W-1:0]  bit_index_ff, bit_index_in;
   logic [CYC_W-1:0]      cycle_count_ff, cycle_count_in;
   logic [HALF_W-1:0]     half_count_ff, half_count_in;
   logic                  carrier_phase_ff, carrier_phase_in;
   logic [SPACE_W-1:0]    space_count_ff, space_count_in;

   // Handshake.
   logic advance;
   logic fire;
   logic req_accept;

   // Per-beat evaluation.
   logic                  is_start;
   logic                  is_tick;
   logic                  seg_end;
   phase_type             ent_from;
   logic                  do_enter;
   logic [HALF_W-1:0]     half_eff;
   logic [HALF_W-1:0]     half_inc;
   logic [CYC_W-1:0]      cycle_inc;
   logic [CYC_W-1:0]      burst_len;
   logic [SPACE_W-1:0]    space_dec;
   logic                  out_level;
   logic                  out_busy;
   logic                  out_done;

   // Data bit search.
   logic [FRAME_BITS-1:0] srch_frame;
   logic [FRAME_BITS-1:0] cand;
   logic [FRAME_BITS-1:0] lowest;
   logic [BIT_IDX_W-1:0]  srch_start;
   logic [BIT_IDX_W-1:0]  srch_idx;
   logic                  srch_found;
   logic [SPACE_W-1:0]    srch_len;
   logic [SPACE_W-1:0]    cur_len;

   assign advance      = !rsp_vld_ff || rsp_if.ready;
   assign req_if.ready = !s1_vld_ff || advance;
   assign req_accept   = req_if.valid && req_if.ready;
   assign fire         = s1_vld_ff && advance;

   assign is_start = fire && (s1_kind_ff == KIND_START);
   assign is_tick  = fire && (s1_kind_ff == KIND_TICK) && (phase_ff != PH_IDLE);

   assign s1_vld_in  = req_accept || (s1_vld_ff && !fire);
   assign rsp_vld_in = fire || (rsp_vld_ff && !rsp_if.ready);

   assign rsp_if.valid      = rsp_vld_ff;
   assign rsp_if.ir_level   = rsp_level_ff;
   assign rsp_if.busy_res   = rsp_busy_ff;
   assign rsp_if.frame_done = rsp_done_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         carrier_half_ff <= CARRIER_HALF_RST;
         lead_burst_ff   <= LEAD_BURST_RST;
         lead_space_ff   <= LEAD_SPACE_RST;
         bit_burst_ff    <= BIT_BURST_RST;
         one_space_ff    <= ONE_SPACE_RST;
         zero_space_ff   <= ZERO_SPACE_RST;
         end_burst_ff    <= END_BURST_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_CARRIER_HALF: carrier_half_ff <= csr_wdata[HALF_W-1:0];
            REG_LEAD_BURST:   lead_burst_ff   <= csr_wdata[CYC_W-1:0];
            REG_LEAD_SPACE:   lead_space_ff   <= csr_wdata[SPACE_W-1:0];
            REG_BIT_BURST:    bit_burst_ff    <= csr_wdata[CYC_W-1:0];
            REG_ONE_SPACE:    one_space_ff    <= csr_wdata[SPACE_W-1:0];
            REG_ZERO_SPACE:   zero_space_ff   <= csr_wdata[SPACE_W-1:0];
            REG_END_BURST:    end_burst_ff    <= csr_wdata[CYC_W-1:0];
            default: ;
         endcase
      end
   end

   // Carrier timing and segment countdown for a tick beat. A burst always ends at the
   // end of a low half period; a space ends when its countdown reaches zero.
   always_comb begin
      half_eff  = (carrier_half_ff == '0) ? HALF_W'(1) : carrier_half_ff;
      half_inc  = half_count_ff + HALF_W'(1);
      cycle_inc = cycle_count_ff + CYC_W'(1);
      space_dec = space_count_ff - SPACE_W'(1);

      unique case (phase_ff)
         PH_LEAD_B: burst_len = lead_burst_ff;
         PH_BIT_B:  burst_len = bit_burst_ff;
         default:   burst_len = end_burst_ff;
      endcase

      half_count_in    = half_count_ff;
      carrier_phase_in = carrier_phase_ff;
      cycle_count_in   = cycle_count_ff;
      space_count_in   = space_count_ff;
      seg_end          = 1'b0;
      out_level        = 1'b0;

      if (is_tick) begin
         unique case (phase_ff)
            PH_LEAD_S, PH_BIT_S: begin
               space_count_in = space_dec;
               seg_end        = (space_dec == '0);
            end
            PH_LEAD_B, PH_BIT_B, PH_END_B: begin
               out_level = !carrier_phase_ff;
               if (half_inc >= half_eff) begin
                  half_count_in = '0;
                  if (!carrier_phase_ff) begin
                     carrier_phase_in = 1'b1;
                  end else begin
                     carrier_phase_in = 1'b0;
                     cycle_count_in   = cycle_inc;
                     seg_end          = (cycle_inc >= burst_len);
                  end
               end else begin
                  half_count_in = half_inc;
               end
            end
            default: ;
         endcase
      end
   end

   // Segment that the sequencer tries to enter next.
   always_comb begin
      do_enter = 1'b0;
      ent_from = PH_IDLE;
      if (is_start && (phase_ff == PH_IDLE)) begin
         do_enter = 1'b1;
         ent_from = PH_LEAD_B;
      end else if (seg_end) begin
         do_enter = 1'b1;
         unique case (phase_ff)
            PH_LEAD_B: ent_from = PH_LEAD_S;
            PH_LEAD_S: ent_from = PH_BIT_B;
            PH_BIT_B:  ent_from = PH_BIT_S;
            PH_BIT_S:  ent_from = PH_BIT_B;
            default:   ent_from = PH_IDLE;
         endcase
      end
   end

   // Finds the first data bit at or after the search start whose space is not empty.
   always_comb begin
      srch_frame = (s1_kind_ff == KIND_START) ? {s1_frame_high_ff, s1_frame_low_ff}
                                              : frame_ff;
      if (phase_ff == PH_IDLE || phase_ff == PH_LEAD_B || phase_ff == PH_LEAD_S) begin
         srch_start = '0;
      end else begin
         srch_start = bit_index_ff + BIT_IDX_W'(1);
      end
      for (int i = 0; i < FRAME_BITS; i++) begin
         cand[i] = (BIT_IDX_W'(i) >= srch_start) &&
                   (srch_frame[i] ? (one_space_ff != '0) : (zero_space_ff != '0));
      end
      lowest     = cand & (~cand + FRAME_BITS'(1));
      srch_found = |cand;
      srch_idx   = '0;
      for (int i = 0; i < FRAME_BITS; i++) begin
         if (lowest[i]) begin
            srch_idx = srch_idx | BIT_IDX_W'(i);
         end
      end
      srch_len = srch_frame[srch_idx] ? one_space_ff : zero_space_ff;
      cur_len  = frame_ff[bit_index_ff] ? one_space_ff : zero_space_ff;
   end

   // Resolves the entry, skipping empty segments, and updates the sequencer state.
   always_comb begin
      phase_type nxt_phase;
      logic      burst_start;
      logic      use_bits;
      logic      use_end;

      nxt_phase    = phase_ff;
      burst_start  = 1'b0;
      use_bits     = 1'b0;
      use_end      = 1'b0;
      frame_in     = frame_ff;
      bit_index_in = bit_index_ff;

      if (is_start && (phase_ff == PH_IDLE)) begin
         frame_in     = srch_frame;
         bit_index_in = '0;
      end

      cycle_count_in_sel: begin
      end

      if (do_enter) begin
         unique case (ent_from)
            PH_LEAD_B: begin
               if (lead_burst_ff != '0) begin
                  nxt_phase   = PH_LEAD_B;
                  burst_start = 1'b1;
               end else if (lead_space_ff != '0) begin
                  nxt_phase = PH_LEAD_S;
               end else begin
                  use_bits = 1'b1;
               end
            end
            PH_LEAD_S: begin
               if (lead_space_ff != '0) begin
                  nxt_phase = PH_LEAD_S;
               end else begin
                  use_bits = 1'b1;
               end
            end
            PH_BIT_B: use_bits = 1'b1;
            PH_BIT_S: begin
               if (cur_len != '0) begin
                  nxt_phase = PH_BIT_S;
               end else begin
                  use_bits = 1'b1;
               end
            end
            default: nxt_phase = PH_IDLE;
         endcase

         if (use_bits) begin
            if (srch_start >= BIT_IDX_W'(FRAME_BITS)) begin
               use_end = 1'b1;
            end else if (bit_burst_ff != '0) begin
               nxt_phase    = PH_BIT_B;
               burst_start  = 1'b1;
               bit_index_in = srch_start;
            end else if (srch_found) begin
               nxt_phase    = PH_BIT_S;
               bit_index_in = srch_idx;
            end else begin
               use_end = 1'b1;
            end
         end

         if (use_end) begin
            bit_index_in = BIT_IDX_W'(FRAME_BITS);
            if (end_burst_ff != '0) begin
               nxt_phase   = PH_END_B;
               burst_start = 1'b1;
            end else begin
               nxt_phase = PH_IDLE;
            end
         end
      end

      phase_in = nxt_phase;
      ent_burst_start = burst_start;
      ent_load_space  = do_enter && !burst_start &&
                        (nxt_phase == PH_LEAD_S || nxt_phase == PH_BIT_S);
      if (nxt_phase == PH_LEAD_S) begin
         ent_space = lead_space_ff;
      end else if (use_bits) begin
         ent_space = srch_len;
      end else begin
         ent_space = cur_len;
      end
   end

   // Result fields. A start beat reports the state right after the frame is entered.
   always_comb begin
      out_busy = 1'b0;
      out_done = 1'b0;
      if (fire) begin
         if (s1_kind_ff == KIND_START) begin
            out_busy = (phase_in != PH_IDLE);
            out_done = (phase_ff == PH_IDLE) && (phase_in == PH_IDLE);
         end else if (phase_ff != PH_IDLE) begin
            out_busy = 1'b1;
            out_done = (phase_in == PH_IDLE);
         end
      end
   end

   logic               ent_burst_start;
   logic               ent_load_space;
   logic [SPACE_W-1:0] ent_space;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff        <= 1'b0;
         rsp_vld_ff       <= 1'b0;
         phase_ff         <= PH_IDLE;
         bit_index_ff     <= '0;
         cycle_count_ff   <= '0;
         half_count_ff    <= '0;
         carrier_phase_ff <= 1'b0;
         space_count_ff   <= '0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (fire) begin
            phase_ff     <= phase_in;
            bit_index_ff <= bit_index_in;
            if (ent_burst_start) begin
               cycle_count_ff   <= '0;
               half_count_ff    <= '0;
               carrier_phase_ff <= 1'b0;
            end else begin
               cycle_count_ff   <= cycle_count_in;
               half_count_ff    <= half_count_in;
               carrier_phase_ff <= carrier_phase_in;
            end
            if (ent_load_space) begin
               space_count_ff <= ent_space;
            end else begin
               space_count_ff <= space_count_in;
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_kind_ff       <= req_if.kind;
         s1_frame_low_ff  <= req_if.frame_low;
         s1_frame_high_ff <= req_if.frame_high;
      end
      if (fire) begin
         frame_ff     <= frame_in;
         rsp_level_ff <= out_level;
         rsp_busy_ff  <= out_busy;
         rsp_done_ff  <= out_done;
      end
   end

   `IPDT_ASSERT_NOW(a_level_needs_busy, rsp_vld_ff && rsp_level_ff, rsp_busy_ff, "IR level high outside a frame")
   `IPDT_ASSERT_NOW(a_done_is_dark, rsp_vld_ff && rsp_done_ff, !rsp_level_ff, "frame ended with the emitter on")
   `IPDT_ASSERT_NOW(a_space_nonzero, (phase_ff == PH_LEAD_S) || (phase_ff == PH_BIT_S), space_count_ff != '0, "space countdown at zero inside a space")
   `IPDT_ASSERT_NOW(a_bit_in_range, (phase_ff == PH_BIT_B) || (phase_ff == PH_BIT_S), bit_index_ff < BIT_IDX_W'(FRAME_BITS), "data bit index past the frame")
   `IPDT_ASSERT_NEXT(a_busy_start_ignored, fire && (s1_kind_ff == KIND_START) && (phase_ff != PH_IDLE), $stable(frame_ff) && $stable(bit_index_ff), "start while busy changed the frame")

endmodule

### tb/sv/ir_pulse_distance_transmitter_test.sv
// Self-checking testbench of the IR pulse-distance transmitter: predicted emitter levels per beat.
module ir_pulse_distance_transmitter_test;
   import ipdt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Stall limit for the watchdog, in cycles without any accepted beat on either channel.
   // The longest legal quiet stretch is the receiver hold-off plus a few gaps.
   localparam int STALL_LIMIT   = 2000;
   // Cycles the receiver holds off during the backpressure test.
   localparam int HOLD_CYCLES   = 150;
   // Extra cycles waited after the last expected level has come back.
   localparam int SETTLE_CYCLES = 8;
   // Number of random beats after which no new random timing set is started.
   localparam int RANDOM_BEATS  = 650;
   // An index with no register behind it; writes there must be dropped.
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   // One emitter result as the block returns it.
   typedef struct packed {
      logic ir_level;
      logic busy_res;
      logic frame_done;
   } tx_level_t;

   // One full set of timing registers.
   typedef struct packed {
      logic [HALF_W-1:0]  half;
      logic [CYC_W-1:0]   lead_burst;
      logic [SPACE_W-1:0] lead_space;
      logic [CYC_W-1:0]   bit_burst;
      logic [SPACE_W-1:0] one_space;
      logic [SPACE_W-1:0] zero_space;
      logic [CYC_W-1:0]   end_burst;
   } tx_timing_t;

   logic clock;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ipdt_req_if req_bus ();
   ipdt_rsp_if rsp_bus ();

   ir_pulse_distance_transmitter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Timing registers as the predictor sees them; they start at the reset values.
   logic [HALF_W-1:0]  cfg_half       = CARRIER_HALF_RST;
   logic [CYC_W-1:0]   cfg_lead_burst = LEAD_BURST_RST;
   logic [SPACE_W-1:0] cfg_lead_space = LEAD_SPACE_RST;
   logic [CYC_W-1:0]   cfg_bit_burst  = BIT_BURST_RST;
   logic [SPACE_W-1:0] cfg_one_space  = ONE_SPACE_RST;
   logic [SPACE_W-1:0] cfg_zero_space = ZERO_SPACE_RST;
   logic [CYC_W-1:0]   cfg_end_burst  = END_BURST_RST;

   // Sequencer state of the predicted transmitter.
   phase_type            tx_phase    = PH_IDLE;
   logic [63:0]          shift_lo    = '0;
   logic [HIGH_BITS-1:0] shift_hi    = '0;
   logic [BIT_IDX_W-1:0] bit_pos     = '0;
   logic [CYC_W-1:0]     cycles_done = '0;
   logic [HALF_W-1:0]    half_ticks  = '0;
   logic                 in_low_half = 1'b0;
   logic [SPACE_W-1:0]   space_left  = '0;

   // Levels predicted for accepted beats, oldest first.
   tx_level_t expected_levels[$];

   int unsigned beats_sent        = 0;
   int unsigned levels_seen       = 0;
   int unsigned mismatch_count    = 0;
   int unsigned src_max_gap       = 18;
   int unsigned snk_max_gap       = 18;
   bit          sink_hold_request = 1'b0;

   // ------------------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------------------

   function automatic void begin_burst(input phase_type seg);
      tx_phase    = seg;
      cycles_done = '0;
      half_ticks  = '0;
      in_low_half = 1'b0;
   endfunction

   // Drops the bit just sent and tells which segment follows it.
   function automatic phase_type advance_bit();
      shift_lo = {shift_hi[0], shift_lo[63:1]};
      shift_hi = shift_hi >> 1;
      bit_pos  = bit_pos + 1'b1;
      return (bit_pos >= FRAME_BITS) ? PH_END_B : PH_BIT_B;
   endfunction

   // Moves into a segment, falling through every segment of zero length on the way.
   function automatic void enter_segment(input phase_type first_seg);
      phase_type          seg;
      logic [SPACE_W-1:0] len;
      seg = first_seg;
      while (1'b1) begin
         case (seg)
            PH_LEAD_B: begin
               if (cfg_lead_burst != 0) begin
                  begin_burst(seg);
                  return;
               end
               seg = PH_LEAD_S;
            end
            PH_LEAD_S: begin
               if (cfg_lead_space != 0) begin
                  tx_phase   = seg;
                  space_left = cfg_lead_space;
                  return;
               end
               seg = PH_BIT_B;
            end
            PH_BIT_B: begin
               if (cfg_bit_burst != 0) begin
                  begin_burst(seg);
                  return;
               end
               seg = PH_BIT_S;
            end
            PH_BIT_S: begin
               len = shift_lo[0] ? cfg_one_space : cfg_zero_space;
               if (len != 0) begin
                  tx_phase   = seg;
                  space_left = len;
                  return;
               end
               seg = advance_bit();
            end
            PH_END_B: begin
               if (cfg_end_burst != 0) begin
                  begin_burst(seg);
                  return;
               end
               seg = PH_IDLE;
            end
            default: begin
               tx_phase = PH_IDLE;
               return;
            end
         endcase
      end
   endfunction

   // Works out the result of one accepted beat and advances the predicted state.
   function automatic tx_level_t step_transmitter(input kind_type kind,
                                                  input logic [63:0] lo,
                                                  input logic [HIGH_BITS-1:0] hi);
      tx_level_t         res;
      logic [HALF_W-1:0] half_len;
      logic [CYC_W-1:0]  burst_len;
      res = '0;
      if (kind == KIND_START) begin
         // A start while a frame is going out changes nothing.
         if (tx_phase == PH_IDLE) begin
            shift_lo = lo;
            shift_hi = hi;
            bit_pos  = '0;
            enter_segment(PH_LEAD_B);
            res.frame_done = (tx_phase == PH_IDLE);
         end
         res.busy_res = (tx_phase != PH_IDLE);
      end else if (tx_phase != PH_IDLE) begin
         res.busy_res = 1'b1;
         if (tx_phase == PH_LEAD_S || tx_phase == PH_BIT_S) begin
            space_left = space_left - 1'b1;
            if (space_left == 0) begin
               if (tx_phase == PH_LEAD_S) enter_segment(PH_BIT_B);
               else enter_segment(advance_bit());
            end
         end else begin
            // A half period of zero behaves as one tick.
            half_len     = (cfg_half == 0) ? 8'd1 : cfg_half;
            res.ir_level = !in_low_half;
            half_ticks   = half_ticks + 1'b1;
            if (half_ticks >= half_len) begin
               half_ticks = '0;
               if (!in_low_half) begin
                  in_low_half = 1'b1;
               end else begin
                  in_low_half = 1'b0;
                  cycles_done = cycles_done + 1'b1;
                  case (tx_phase)
                     PH_LEAD_B: burst_len = cfg_lead_burst;
                     PH_BIT_B:  burst_len = cfg_bit_burst;
                     default:   burst_len = cfg_end_burst;
                  endcase
                  if (cycles_done >= burst_len) begin
                     case (tx_phase)
                        PH_LEAD_B: enter_segment(PH_LEAD_S);
                        PH_BIT_B:  enter_segment(PH_BIT_S);
                        default:   enter_segment(PH_IDLE);
                     endcase
                  end
               end
            end
         end
         res.frame_done = (tx_phase == PH_IDLE);
      end
      return res;
   endfunction

   // ------------------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------------------

   // Frame contents of several densities: dense, sparse, empty and all ones.
   function automatic void pick_frame(output logic [63:0] lo, output logic [HIGH_BITS-1:0] hi);
      case ($urandom_range(0, 5))
         0: begin
            lo = {$urandom, $urandom};
            hi = $urandom;
         end
         4: begin
            lo = '0;
            hi = '0;
         end
         5: begin
            lo = '1;
            hi = '1;
         end
         default: begin
            lo = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            hi = $urandom & $urandom & $urandom;
         end
      endcase
   endfunction

   // Short random timings, with empty segments common.
   function automatic tx_timing_t rand_timing();
      tx_timing_t t;
      t.half       = $urandom_range(0, 3);
      t.lead_burst = $urandom_range(0, 3);
      t.lead_space = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 6);
      t.bit_burst  = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
      t.one_space  = $urandom_range(0, 5);
      t.zero_space = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
      t.end_burst  = $urandom_range(0, 3);
      return t;
   endfunction

   // Offers one beat after a random gap, waits for it to be taken and records the
   // predicted level. The valid stays high when the next beat follows without a gap.
   task automatic send_beat(input kind_type kind, input logic [63:0] lo,
                            input logic [HIGH_BITS-1:0] hi);
      int unsigned gap;
      gap = $urandom_range(0, src_max_gap);
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
      end
      @(negedge clock);
      req_bus.valid      = 1'b1;
      req_bus.kind       = kind;
      req_bus.frame_low  = lo;
      req_bus.frame_high = hi;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      expected_levels.push_back(step_transmitter(kind, lo, hi));
      beats_sent++;
   endtask

   // Ticks until the predicted frame is over; with noise some ticks become starts that
   // the busy block must ignore. Tick payloads are random since the block ignores them.
   task automatic run_frame_out(input bit with_noise);
      logic [63:0]          lo;
      logic [HIGH_BITS-1:0] hi;
      while (tx_phase != PH_IDLE) begin
         pick_frame(lo, hi);
         if (with_noise && $urandom_range(0, 15) == 0) send_beat(KIND_START, lo, hi);
         else send_beat(KIND_TICK, lo, hi);
      end
   endtask

   // Stops offering beats and waits until every predicted level has come back.
   task automatic settle_levels();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (expected_levels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      case (idx)
         REG_CARRIER_HALF: cfg_half       = data[HALF_W-1:0];
         REG_LEAD_BURST:   cfg_lead_burst = data[CYC_W-1:0];
         REG_LEAD_SPACE:   cfg_lead_space = data[SPACE_W-1:0];
         REG_BIT_BURST:    cfg_bit_burst  = data[CYC_W-1:0];
         REG_ONE_SPACE:    cfg_one_space  = data[SPACE_W-1:0];
         REG_ZERO_SPACE:   cfg_zero_space = data[SPACE_W-1:0];
         REG_END_BURST:    cfg_end_burst  = data[CYC_W-1:0];
         default: ;
      endcase
   endtask

   // Writes a whole timing set once the block has drained. Bits above a register's width
   // carry junk that must be dropped, and the unused index gets a write as well.
   task automatic load_timing(input tx_timing_t t);
      logic [CSR_DATA_W-1:0] junk;
      settle_levels();
      junk = $urandom;
      write_reg(REG_CARRIER_HALF, {junk[7:0], t.half});
      write_reg(REG_LEAD_BURST,   {junk[5:0], t.lead_burst});
      write_reg(REG_LEAD_SPACE,   t.lead_space);
      write_reg(REG_BIT_BURST,    {junk[15:10], t.bit_burst});
      write_reg(REG_ONE_SPACE,    t.one_space);
      write_reg(REG_ZERO_SPACE,   t.zero_space);
      write_reg(REG_END_BURST,    {junk[11:6], t.end_burst});
      write_reg(REG_UNUSED,       $urandom);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // ------------------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------------------

   // Reset timings, idle ticks, an ignored start, a timing change in the middle of a
   // frame, a frame whose segments are all empty and a half period of zero.
   task automatic test_directed();
      tx_timing_t t;
      // Ticks while idle must come back low and not busy.
      send_beat(KIND_TICK, '1, '1);
      send_beat(KIND_TICK, '0, '0);
      // With the reset half period of 13 ticks the lead burst is high for 13 ticks, then low.
      send_beat(KIND_START, '1, '1);
      repeat (14) send_beat(KIND_TICK, '0, '0);
      send_beat(KIND_START, '0, '0);
      // Shorten everything while the lead burst runs: the burst ends on its new count.
      t = '{8'd1, 10'd1, 16'd1, 10'd0, 16'd0, 16'd0, 10'd1};
      load_timing(t);
      run_frame_out(1'b0);
      // Every segment empty: the start beat itself reports the frame as done.
      t = '{8'd0, 10'd0, 16'd0, 10'd0, 16'd0, 16'd0, 10'd0};
      load_timing(t);
      send_beat(KIND_START, '1, '1);
      send_beat(KIND_TICK, '0, '0);
      // Half period of zero acts as one; only frame bit 71 is set, so the skip over empty
      // bits runs through the whole frame before the last space.
      t = '{8'd0, 10'd1, 16'd0, 10'd0, 16'd2, 16'd0, 10'd1};
      load_timing(t);
      send_beat(KIND_START, '0, 8'h80);
      run_frame_out(1'b0);
   endtask

   // The receiver holds off while the sender keeps offering ticks back to back, so the
   // block fills up and stalls its input; then the sender waits until all levels are in.
   task automatic test_backpressure();
      tx_timing_t           t;
      logic [63:0]          lo;
      logic [HIGH_BITS-1:0] hi;
      t = '{8'd1, 10'd2, 16'd3, 10'd1, 16'd2, 16'd1, 10'd1};
      load_timing(t);
      src_max_gap = 0;
      pick_frame(lo, hi);
      send_beat(KIND_START, lo, hi);
      sink_hold_request = 1'b1;
      repeat (40) send_beat(KIND_TICK, lo, hi);
      run_frame_out(1'b1);
      settle_levels();
      src_max_gap = 18;
   endtask

   // Random timing sets, each carrying one to three frames with random contents and
   // stray ticks and starts, under random idling on both sides.
   task automatic test_random_frames();
      int unsigned          stop_at;
      logic [63:0]          lo;
      logic [HIGH_BITS-1:0] hi;
      stop_at = beats_sent + RANDOM_BEATS;
      while (beats_sent < stop_at) begin
         // About a quarter of the sets run with no idling on one side or the other.
         src_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 18;
         snk_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 18;
         load_timing(rand_timing());
         repeat ($urandom_range(1, 3)) begin
            repeat ($urandom_range(0, 2)) begin
               pick_frame(lo, hi);
               send_beat(KIND_TICK, lo, hi);
            end
            pick_frame(lo, hi);
            send_beat(KIND_START, lo, hi);
            run_frame_out(1'b1);
         end
      end
      src_max_gap = 18;
      snk_max_gap = 18;
   endtask

   // Every register at its maximum. The frame cannot finish in a short run, but the lead
   // burst shows a full 255-tick high half and the turn to the low half.
   task automatic test_extremes();
      tx_timing_t t;
      t = '{8'hFF, 10'h3FF, 16'hFFFF, 10'h3FF, 16'hFFFF, 16'hFFFF, 10'h3FF};
      load_timing(t);
      send_beat(KIND_START, {$urandom, $urandom}, $urandom);
      send_beat(KIND_START, '0, '0);
      repeat (260) send_beat(KIND_TICK, {$urandom, $urandom}, $urandom);
   endtask

   // ------------------------------------------------------------------------------------
   // Clock, receiver, watchdog and test sequence
   // ------------------------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: draws a hold-off per level, takes the level at a rising edge and compares
   // it with the oldest prediction.
   initial begin
      int unsigned hold;
      tx_level_t   want;
      tx_level_t   got;
      rsp_bus.ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (sink_hold_request) begin
            sink_hold_request = 1'b0;
            hold = HOLD_CYCLES;
         end else begin
            hold = $urandom_range(0, snk_max_gap);
         end
         repeat (hold) begin
            @(negedge clock);
            rsp_bus.ready = 1'b0;
         end
         @(negedge clock);
         rsp_bus.ready = 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         got = {rsp_bus.ir_level, rsp_bus.busy_res, rsp_bus.frame_done};
         levels_seen++;
         if (expected_levels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("level beat %0d at %0t ns arrived with nothing expected", levels_seen,
                        $time);
         end else begin
            want = expected_levels.pop_front();
            if (got.ir_level !== want.ir_level || got.busy_res !== want.busy_res ||
                got.frame_done !== want.frame_done) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"level beat %0d at %0t ns: expected ir_level %b busy_res %b ",
                            "frame_done %b, got ir_level %b busy_res %b frame_done %b"},
                           levels_seen, $time, want.ir_level, want.busy_res,
                           want.frame_done, got.ir_level, got.busy_res, got.frame_done);
            end
         end
      end
   end

   // Watchdog: ends the run when no beat moves on either channel for too long.
   initial begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("ir_pulse_distance_transmitter_test: FAIL");
      $finish;
   end

   // Test sequence: reset, then the tests in turn, then the drain and the verdict.
   initial begin
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = REG_CARRIER_HALF;
      csr_wdata          = '0;
      req_bus.valid      = 1'b0;
      req_bus.kind       = KIND_TICK;
      req_bus.frame_low  = '0;
      req_bus.frame_high = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_backpressure();
      test_random_frames();
      test_extremes();

      settle_levels();
      if (mismatch_count == 0) begin
         $display("ir_pulse_distance_transmitter_test: PASS");
      end else begin
         $display("ir_pulse_distance_transmitter_test: FAIL");
      end
      $finish;
   end

endmodule
